// ===== hdl/hhke_pkg.sv =====
// Package for the HTTP header key extractor: character codes, result status codes,
// name table and the command/status structs between controller and datapath.
// No dependencies.
package hhke_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [4:0] NAME_LEN = 5'd17;

    localparam logic [1:0] STATUS_KEY       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY     = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic name_en;
        logic name_open;
        logic value_en;
        logic value_lead;
        logic clear_line;
        logic rd_first;
        logic rd_issue;
        logic rd_next;
        logic set_empty;
        logic set_not_found;
    } dp_cmd_t;

    typedef struct packed {
        logic is_lf;
        logic is_colon;
        logic is_ws;
        logic name_hit;
        logic value_empty;
        logic out_last;
    } dp_sts_t;

    function automatic logic [7:0] target_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:    c = 8'h73; // s
            5'd1:    c = 8'h65; // e
            5'd2:    c = 8'h63; // c
            5'd3:    c = 8'h2D; // -
            5'd4:    c = 8'h77; // w
            5'd5:    c = 8'h65; // e
            5'd6:    c = 8'h62; // b
            5'd7:    c = 8'h73; // s
            5'd8:    c = 8'h6F; // o
            5'd9:    c = 8'h63; // c
            5'd10:   c = 8'h6B; // k
            5'd11:   c = 8'h65; // e
            5'd12:   c = 8'h74; // t
            5'd13:   c = 8'h2D; // -
            5'd14:   c = 8'h6B; // k
            5'd15:   c = 8'h65; // e
            5'd16:   c = 8'h79; // y
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage

// ===== hdl/hhke_datapath.sv =====
// Datapath of the HTTP header key extractor: name matcher, value store,
// value counters and result registers. Depends on hhke_pkg.
module hhke_datapath #(
    parameter int KEY_MAX = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       in_byte,
    input  hhke_pkg::dp_cmd_t cmd,
    output hhke_pkg::dp_sts_t sts,
    output logic [7:0]       key_byte,
    output logic [1:0]       status,
    output logic             truncated,
    output logic             last
);
    import hhke_pkg::*;

    localparam int AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int CW = $clog2(KEY_MAX + 1);
    localparam logic [CW-1:0] KEY_MAX_C = CW'(KEY_MAX);

    logic [7:0]    value_store [KEY_MAX];
    logic [7:0]    rd_data_reg;

    logic [4:0]    match_cnt_reg, match_cnt_next;
    logic          mismatch_reg, mismatch_next;
    logic          trail_reg, trail_next;
    logic [CW-1:0] value_count_reg, value_count_next;
    logic [CW-1:0] trimmed_len_reg, trimmed_len_next;
    logic          overflow_reg, overflow_next;
    logic [1:0]    status_reg, status_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;

    logic          ws;
    logic          value_take;
    logic          wr_en;
    logic          rd_last;

    assign ws         = is_space(in_byte);
    assign value_take = cmd.value_en && !(cmd.value_lead && ws);
    assign wr_en      = value_take && !cmd.clear_line && (value_count_reg < KEY_MAX_C);
    assign rd_last    = (CW'(rd_idx_reg) + CW'(1)) == trimmed_len_reg;

    assign sts.is_lf       = (in_byte == CH_LF);
    assign sts.is_colon    = (in_byte == CH_COLON);
    assign sts.is_ws       = ws;
    assign sts.name_hit    = !mismatch_reg && (match_cnt_reg == NAME_LEN);
    assign sts.value_empty = (trimmed_len_reg == '0);
    assign sts.out_last    = last;

    always_comb
    begin
        match_cnt_next   = match_cnt_reg;
        mismatch_next    = mismatch_reg;
        trail_next       = trail_reg;
        value_count_next = value_count_reg;
        trimmed_len_next = trimmed_len_reg;
        overflow_next    = overflow_reg;
        status_next      = status_reg;
        rd_idx_next      = rd_idx_reg;

        if (cmd.clear_line)
        begin
            match_cnt_next   = '0;
            mismatch_next    = 1'b0;
            trail_next       = 1'b0;
            value_count_next = '0;
            trimmed_len_next = '0;
            overflow_next    = 1'b0;
        end
        else if (cmd.name_en)
        begin
            if (in_byte == CH_COLON)
            begin
                value_count_next = '0;
                trimmed_len_next = '0;
                overflow_next    = 1'b0;
            end
            else if (ws)
            begin
                if (cmd.name_open)
                begin
                    trail_next = 1'b1;
                end
            end
            else if (trail_reg || (match_cnt_reg >= NAME_LEN) ||
                     (to_lower(in_byte) != target_char(match_cnt_reg)))
            begin
                mismatch_next = 1'b1;
            end
            else
            begin
                match_cnt_next = match_cnt_reg + 5'd1;
            end
        end
        else if (value_take)
        begin
            if (value_count_reg < KEY_MAX_C)
            begin
                if (!ws)
                begin
                    trimmed_len_next = value_count_reg + CW'(1);
                end
                value_count_next = value_count_reg + CW'(1);
            end
            else if (!ws)
            begin
                overflow_next = 1'b1;
            end
        end

        if (cmd.rd_first)
        begin
            status_next = STATUS_KEY;
            rd_idx_next = '0;
        end
        if (cmd.set_empty)
        begin
            status_next = STATUS_EMPTY;
        end
        if (cmd.set_not_found)
        begin
            status_next = STATUS_NOT_FOUND;
        end
        if (cmd.rd_next)
        begin
            rd_idx_next = rd_idx_reg + AW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_cnt_reg   <= '0;
            mismatch_reg    <= 1'b0;
            trail_reg       <= 1'b0;
            value_count_reg <= '0;
            trimmed_len_reg <= '0;
            overflow_reg    <= 1'b0;
            status_reg      <= STATUS_KEY;
            rd_idx_reg      <= '0;
        end
        else
        begin
            match_cnt_reg   <= match_cnt_next;
            mismatch_reg    <= mismatch_next;
            trail_reg       <= trail_next;
            value_count_reg <= value_count_next;
            trimmed_len_reg <= trimmed_len_next;
            overflow_reg    <= overflow_next;
            status_reg      <= status_next;
            rd_idx_reg      <= rd_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_store[value_count_reg[AW-1:0]] <= in_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= value_store[rd_idx_reg];
        end
    end

    assign status    = status_reg;
    assign key_byte  = (status_reg == STATUS_KEY) ? rd_data_reg : 8'h00;
    assign truncated = (status_reg == STATUS_KEY) && overflow_reg;
    assign last      = (status_reg != STATUS_KEY) || rd_last;

endmodule

// ===== hdl/hhke_controller.sv =====
// Controller of the HTTP header key extractor: line parse phases, key run
// readout and handshakes. Depends on hhke_pkg.
module hhke_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    input  hhke_pkg::dp_sts_t sts,
    output hhke_pkg::dp_cmd_t cmd
);
    import hhke_pkg::*;

    localparam logic [2:0] S_NAME_LEAD  = 3'd0;
    localparam logic [2:0] S_NAME       = 3'd1;
    localparam logic [2:0] S_SKIP       = 3'd2;
    localparam logic [2:0] S_VALUE_LEAD = 3'd3;
    localparam logic [2:0] S_VALUE      = 3'd4;
    localparam logic [2:0] S_DONE       = 3'd5;
    localparam logic [2:0] S_EMIT       = 3'd6;
    localparam logic [2:0] S_OUT        = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       eor_pend_reg, eor_pend_next;
    logic       rd_pend_reg, rd_pend_next;
    logic       accept;
    logic       in_value;
    logic [2:0] phase;

    assign in_ready  = (state_reg != S_EMIT) && (state_reg != S_OUT);
    assign out_valid = (state_reg == S_OUT) && !rd_pend_reg;
    assign accept    = in_valid && in_ready;
    assign in_value  = (state_reg == S_VALUE_LEAD) || (state_reg == S_VALUE);

    always_comb
    begin
        state_next    = state_reg;
        eor_pend_next = eor_pend_reg;
        rd_pend_next  = 1'b0;
        cmd           = '0;
        phase         = state_reg;

        unique case (state_reg) inside
            S_NAME_LEAD, S_NAME, S_SKIP, S_VALUE_LEAD, S_VALUE:
            begin
                if (accept)
                begin
                    if (sts.is_lf)
                    begin
                        if (in_value)
                        begin
                            state_next    = S_EMIT;
                            eor_pend_next = in_last;
                        end
                        else
                        begin
                            cmd.clear_line = 1'b1;
                            if (in_last)
                            begin
                                cmd.set_not_found = 1'b1;
                                state_next        = S_OUT;
                                eor_pend_next     = 1'b1;
                            end
                            else
                            begin
                                state_next = S_NAME_LEAD;
                            end
                        end
                    end
                    else
                    begin
                        if ((state_reg == S_NAME_LEAD) || (state_reg == S_NAME))
                        begin
                            cmd.name_en   = 1'b1;
                            cmd.name_open = (state_reg == S_NAME);
                            if (sts.is_colon)
                            begin
                                phase = sts.name_hit ? S_VALUE_LEAD : S_SKIP;
                            end
                            else if (!sts.is_ws)
                            begin
                                phase = S_NAME;
                            end
                        end
                        else if (in_value)
                        begin
                            cmd.value_en   = 1'b1;
                            cmd.value_lead = (state_reg == S_VALUE_LEAD);
                            if (!sts.is_ws)
                            begin
                                phase = S_VALUE;
                            end
                        end

                        if (in_last)
                        begin
                            eor_pend_next = 1'b1;
                            if ((phase == S_VALUE_LEAD) || (phase == S_VALUE))
                            begin
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                cmd.clear_line    = 1'b1;
                                cmd.set_not_found = 1'b1;
                                state_next        = S_OUT;
                            end
                        end
                        else
                        begin
                            state_next = phase;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (accept && in_last)
                begin
                    cmd.clear_line = 1'b1;
                    state_next     = S_NAME_LEAD;
                end
            end
            S_EMIT:
            begin
                state_next = S_OUT;
                if (sts.value_empty)
                begin
                    cmd.set_empty = 1'b1;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    rd_pend_next = 1'b1;
                end
            end
            S_OUT:
            begin
                if (rd_pend_reg)
                begin
                    cmd.rd_issue = 1'b1;
                end
                else if (out_ready)
                begin
                    if (sts.out_last)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = eor_pend_reg ? S_NAME_LEAD : S_DONE;
                    end
                    else
                    begin
                        cmd.rd_next  = 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_NAME_LEAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_NAME_LEAD;
            eor_pend_reg <= 1'b0;
            rd_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            eor_pend_reg <= eor_pend_next;
            rd_pend_reg  <= rd_pend_next;
        end
    end

endmodule

// ===== hdl/http_header_key_extract.sv =====
// Top level of the HTTP header key extractor: joins controller and datapath
// to the stream ports. Depends on hhke_pkg, hhke_controller, hhke_datapath.
//
// Usage: request bytes enter on the s_axis channel, one per transaction, with
// s_axis_tlast on the final byte of the request. Results leave on m_axis.
// For the first line whose name is sec-websocket-key (trimmed, any case) the
// trimmed value is sent as a run of key bytes with tuser status 0, tlast on
// the final byte and the truncated flag set when the value exceeded KEY_MAX
// bytes. A matching line with an all-whitespace value gives one status-1
// result; a request without a match gives one status-2 result at its end.
// Throughput: one request byte per cycle while parsing. A not-found result is
// valid the cycle after the final byte. A key run follows the EMIT state; each
// byte is read from the value store and registered before it is shown, and the
// next read is issued only once the previous byte has been taken.
// The input is held off (s_axis_tready low) from the line end until the last
// transaction of the run; a stalled receiver holds the current result.
// Reset puts the parser at the start of a line with no result pending.
module http_header_key_extract #(
    parameter int KEY_MAX = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] request_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] key_byte
    output logic [2:0] m_axis_tuser,  // [1:0] status, [2] truncated
    output logic       m_axis_tlast
);
    import hhke_pkg::*;

    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic [1:0] status;
    logic       truncated;

    hhke_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hhke_datapath #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_byte   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .key_byte  (m_axis_tdata),
        .status    (status),
        .truncated (truncated),
        .last      (m_axis_tlast)
    );

    assign m_axis_tuser = {truncated, status};

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input accepted while a result is pending");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_KEY)) |-> m_axis_tlast)
        else $error("status result without tlast");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid && s_axis_tready))
        else $error("output not released after final transaction");
`endif

endmodule
